// ===== rtl/caq_pkg.sv =====
// Shared types, sizes and codes for the concurrency admission queue.
// Used by caq_ctrl, caq_datapath and concurrency_admission_queue_core; no dependencies.
package caq_pkg;

    // Queue depth and tag space; both are powers of two so that index
    // arithmetic wraps by truncation.
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_COUNT   = 64;

    localparam int KIND_W     = 2;
    localparam int TAG_W      = 6;
    localparam int REL_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 8;
    localparam int CAP_W      = 5;
    localparam int TS_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam int QA_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TI_W   = $clog2(TAG_COUNT);
    localparam int TAGX_W = (TI_W > TAG_W) ? TI_W : TAG_W;
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_REQUEST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SHUTDOWN = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FAILED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WAITING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TIMEDOUT = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STOPPED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOEFFECT = 3'd6;

    // Per-tag state codes.
    localparam logic [TS_W-1:0] TS_IDLE     = 2'd0;
    localparam logic [TS_W-1:0] TS_WAITING  = 2'd1;
    localparam logic [TS_W-1:0] TS_TIMEDOUT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CONC  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_CAP = 1'd1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [REL_W-1:0]  release_count;
    } caq_in_t;

    typedef struct packed {
        logic [TAG_W-1:0]    result_tag;
        logic [STATUS_W-1:0] status;
        logic                last;
    } caq_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic req_exec;
        logic ts_read_item;
        logic to_exec;
        logic rel_sub;
        logic stop_set;
        logic walk_read;
        logic walk_pop;
        logic finish;
        logic ts_clear;
    } caq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              walk_ok;
    } caq_stat_t;

    function automatic logic [TI_W-1:0] tag_index(input logic [TAG_W-1:0] t);
        logic [TAGX_W-1:0] x;
        x = TAGX_W'(t);
        return x[TI_W-1:0];
    endfunction

endpackage

// ===== rtl/caq_ctrl.sv =====
// Sequencing state machine for the admission queue.
// Depends on caq_pkg for the command and status structs.
module caq_ctrl
    import caq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  caq_stat_t stat,
    output logic      busy,
    output caq_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_REQ      = 4'd2;
    localparam logic [3:0] S_TO_RD    = 4'd3;
    localparam logic [3:0] S_TO_EVAL  = 4'd4;
    localparam logic [3:0] S_REL_SUB  = 4'd5;
    localparam logic [3:0] S_STOP     = 4'd6;
    localparam logic [3:0] S_WALK_RD  = 4'd7;
    localparam logic [3:0] S_WALK_POP = 4'd8;
    localparam logic [3:0] S_FINISH   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.kind)
                    KIND_REQUEST:  state_next = S_REQ;
                    KIND_RELEASE:  state_next = S_REL_SUB;
                    KIND_TIMEOUT:  state_next = S_TO_RD;
                    KIND_SHUTDOWN: state_next = S_STOP;
                    default:       state_next = S_FINISH;
                endcase
            end
            S_REQ:
            begin
                cmd.req_exec = 1'b1;
                state_next   = S_FINISH;
            end
            S_TO_RD:
            begin
                cmd.ts_read_item = 1'b1;
                state_next       = S_TO_EVAL;
            end
            S_TO_EVAL:
            begin
                cmd.to_exec = 1'b1;
                state_next  = S_FINISH;
            end
            S_REL_SUB:
            begin
                cmd.rel_sub = 1'b1;
                state_next  = S_WALK_RD;
            end
            S_STOP:
            begin
                cmd.stop_set = 1'b1;
                state_next   = S_WALK_RD;
            end
            S_WALK_RD:
            begin
                if (stat.walk_ok)
                begin
                    cmd.walk_read = 1'b1;
                    state_next    = S_WALK_POP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_WALK_POP:
            begin
                cmd.walk_pop = 1'b1;
                state_next   = S_WALK_RD;
            end
            S_FINISH:
            begin
                cmd.finish   = 1'b1;
                cmd.ts_clear = (stat.kind == KIND_SHUTDOWN);
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    // Every item ends in exactly one finish step before busy drops.
    a_finish_before_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(cmd.finish))
        else $error("busy dropped without a finish step");

    // A pop always consumes the tag state read in the cycle before it.
    a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_pop |-> $past(cmd.walk_read))
        else $error("queue pop without a preceding tag state read");

    // While idle no work command is issued.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !(cmd.req_exec || cmd.walk_pop || cmd.walk_read || cmd.finish))
        else $error("work command while idle");

endmodule

// ===== rtl/caq_datapath.sv =====
// Datapath: configuration, grant count, wait queue, tag state memory and result staging.
// Depends on caq_pkg; driven by caq_ctrl through caq_cmd_t.
module caq_datapath
    import caq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  caq_in_t               item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  caq_cmd_t              cmd,
    output caq_stat_t             stat,
    output logic                  result_strobe,
    output caq_out_t              result
);

    logic [COUNT_W-1:0] max_reg,     max_next;
    logic [CAP_W-1:0]   qcap_reg,    qcap_next;
    caq_in_t            item_reg,    item_next;
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic [QA_W-1:0]    head_reg,    head_next;
    logic [FILL_W-1:0]  fill_reg,    fill_next;
    logic               stopped_reg, stopped_next;
    logic [TAG_W-1:0]   pend_tag_reg,    pend_tag_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic               pend_valid_reg,  pend_valid_next;
    caq_out_t           result_reg,  result_next;
    logic               strobe_reg,  strobe_next;

    // Wait queue entries, written at the tail and read only at the head.
    logic [TAG_W-1:0]   fifo_reg [QUEUE_DEPTH];
    logic               fifo_we;
    logic [QA_W-1:0]    fifo_widx;

    // Tag state memory with one valid bit per entry; invalid reads as idle.
    logic [TS_W-1:0]    ts_mem [TAG_COUNT];
    logic [TAG_COUNT-1:0] ts_valid_reg, ts_valid_next;
    logic [TS_W-1:0]    ts_rd_reg;
    logic               ts_we;
    logic [TI_W-1:0]    ts_widx;
    logic [TS_W-1:0]    ts_wdata;
    logic [TI_W-1:0]    ts_ridx;

    logic [TAG_W-1:0]   head_tag;
    logic [TI_W-1:0]    head_idx;
    logic [TI_W-1:0]    item_idx;
    logic               emit_en;
    logic [TAG_W-1:0]   emit_tag;
    logic [STATUS_W-1:0] emit_status;
    logic               queue_full;

    assign head_tag = fifo_reg[head_reg];
    assign head_idx = tag_index(head_tag);
    assign item_idx = tag_index(item_reg.tag);
    assign ts_ridx  = cmd.walk_read ? head_idx : item_idx;
    assign queue_full = (CMP_W'(fill_reg) == CMP_W'(qcap_reg))
                     || (fill_reg == FILL_W'(QUEUE_DEPTH));

    assign stat.kind    = item_reg.kind;
    assign stat.walk_ok = (fill_reg != '0)
        && ((item_reg.kind == KIND_SHUTDOWN) || ((count_reg < max_reg) && !stopped_reg));

    always_comb
    begin
        max_next         = max_reg;
        qcap_next        = qcap_reg;
        item_next        = item_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        fill_next        = fill_reg;
        stopped_next     = stopped_reg;
        pend_tag_next    = pend_tag_reg;
        pend_status_next = pend_status_reg;
        pend_valid_next  = pend_valid_reg;
        result_next      = result_reg;
        strobe_next      = 1'b0;
        ts_valid_next    = ts_valid_reg;
        fifo_we          = 1'b0;
        fifo_widx        = head_reg + fill_reg[QA_W-1:0];
        ts_we            = 1'b0;
        ts_widx          = item_idx;
        ts_wdata         = TS_IDLE;
        emit_en          = 1'b0;
        emit_tag         = item_reg.tag;
        emit_status      = ST_NOEFFECT;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_CONC:  max_next  = cfg_data;
                REG_QUEUE_CAP: qcap_next = cfg_data[CAP_W-1:0];
                default: ;
            endcase
        end

        if (cmd.load)
            item_next = item;

        if (cmd.req_exec)
        begin
            emit_en = 1'b1;
            if ((max_reg == '0) || stopped_reg)
            begin
                emit_status = ST_FAILED;
            end
            else if (queue_full)
            begin
                emit_status = ST_OVERSIZE;
            end
            else if (count_reg < max_reg)
            begin
                count_next  = count_reg + COUNT_W'(1);
                emit_status = ST_GRANTED;
            end
            else
            begin
                fifo_we     = 1'b1;
                fill_next   = fill_reg + FILL_W'(1);
                ts_we       = 1'b1;
                ts_wdata    = TS_WAITING;
                emit_status = ST_WAITING;
            end
        end

        if (cmd.to_exec)
        begin
            emit_en = 1'b1;
            if (ts_rd_reg == TS_WAITING)
            begin
                ts_we       = 1'b1;
                ts_wdata    = TS_TIMEDOUT;
                emit_status = ST_TIMEDOUT;
            end
        end

        if (cmd.rel_sub)
            count_next = (count_reg >= item_reg.release_count)
                       ? count_reg - item_reg.release_count : '0;

        if (cmd.stop_set)
            stopped_next = 1'b1;

        if (cmd.walk_pop)
        begin
            head_next = head_reg + QA_W'(1);
            fill_next = fill_reg - FILL_W'(1);
            ts_we     = 1'b1;
            ts_widx   = head_idx;
            ts_wdata  = TS_IDLE;
            if (ts_rd_reg != TS_TIMEDOUT)
            begin
                emit_en  = 1'b1;
                emit_tag = head_tag;
                if (item_reg.kind == KIND_RELEASE)
                begin
                    count_next  = count_reg + COUNT_W'(1);
                    emit_status = ST_GRANTED;
                end
                else
                begin
                    emit_status = ST_STOPPED;
                end
            end
        end

        if (ts_we)
            ts_valid_next[ts_widx] = 1'b1;
        if (cmd.ts_clear)
            ts_valid_next = '0;

        // One result is held back so that the final one can carry last.
        if (emit_en)
        begin
            if (pend_valid_reg)
            begin
                strobe_next            = 1'b1;
                result_next.result_tag = pend_tag_reg;
                result_next.status     = pend_status_reg;
                result_next.last       = 1'b0;
            end
            pend_valid_next  = 1'b1;
            pend_tag_next    = emit_tag;
            pend_status_next = emit_status;
        end

        if (cmd.finish)
        begin
            strobe_next      = 1'b1;
            result_next.last = 1'b1;
            pend_valid_next  = 1'b0;
            if (pend_valid_reg)
            begin
                result_next.result_tag = pend_tag_reg;
                result_next.status     = pend_status_reg;
            end
            else
            begin
                result_next.result_tag = '0;
                result_next.status     = ST_NOEFFECT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg        <= '0;
            qcap_reg       <= '0;
            count_reg      <= '0;
            head_reg       <= '0;
            fill_reg       <= '0;
            stopped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            ts_valid_reg   <= '0;
        end
        else
        begin
            max_reg        <= max_next;
            qcap_reg       <= qcap_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            stopped_reg    <= stopped_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
            ts_valid_reg   <= ts_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg        <= item_next;
        pend_tag_reg    <= pend_tag_next;
        pend_status_reg <= pend_status_next;
        result_reg      <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (fifo_we)
            fifo_reg[fifo_widx] <= item_reg.tag;
    end

    always_ff @(posedge clk)
    begin
        if (ts_we)
            ts_mem[ts_widx] <= ts_wdata;
        ts_rd_reg <= ts_valid_reg[ts_ridx] ? ts_mem[ts_ridx] : TS_IDLE;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("wait queue fill beyond its depth");

    // The final result of an item is never directly followed by another one.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |=> !result_strobe)
        else $error("result right after a final result");

    a_stopped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stopped flag cleared without reset");

endmodule

// ===== rtl/concurrency_admission_queue_core.sv =====
// Top level of the concurrency admission queue: controller plus datapath.
// Depends on caq_pkg, caq_ctrl and caq_datapath.
//
//   Channel   Ports                                 Handshake
//   -------   -----------------------------------   ---------------------------------
//   request   start, busy, item                     taken when start is high, busy low
//   result    result_strobe, result                 one cycle per result, no stall
//   config    cfg_we, cfg_index, cfg_data           written on any edge with cfg_we
//
// Steps: a request is dispatched, executed and finished. A timeout first reads the tag
// state memory, then is evaluated. A release subtracts its release count, and a shutdown
// sets the stopped flag; both then walk the wait queue, and each entry needs a tag state
// memory read before it is popped.
// The last result of an item carries last = 1.
// Reset (rst_n low, asynchronous) clears the count, queue pointers, stopped flag,
// configuration and all tag state valid bits; no clearing pass is needed.
// The receiver cannot stall: each result is valid for exactly one cycle.
module concurrency_admission_queue_core
    import caq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  caq_in_t               item,
    output logic                  result_strobe,
    output caq_out_t              result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // The controller sequences each request and holds only its state register; the datapath owns all other state.
    caq_cmd_t  cmd;
    caq_stat_t stat;

    caq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // The item is captured on the accepting edge, so it need not be held afterward.
    caq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .stat          (stat),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule
